/* rtl/srarq_pkg.sv */
// Package for the selective-repeat ARQ link: item types, event and action codes, states.
package srarq_pkg;

   localparam logic [2:0] EV_PACKET   = 3'd0;
   localparam logic [2:0] EV_PHYS_RDY = 3'd1;
   localparam logic [2:0] EV_FRAME    = 3'd2;
   localparam logic [2:0] EV_DATA_TO  = 3'd3;
   localparam logic [2:0] EV_ACK_TO   = 3'd4;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_ACK  = 2'd1;
   localparam logic [1:0] KIND_NAK  = 2'd2;

   localparam logic [2:0] ACT_SEND_DATA = 3'd0;
   localparam logic [2:0] ACT_SEND_ACK  = 3'd1;
   localparam logic [2:0] ACT_SEND_NAK  = 3'd2;
   localparam logic [2:0] ACT_DELIVER   = 3'd3;
   localparam logic [2:0] ACT_STOP_TMR  = 3'd4;
   localparam logic [2:0] ACT_STATUS    = 3'd5;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [63:0] payload;
      logic        rx_good;
      logic [1:0]  rx_kind;
      logic [4:0]  rx_seq;
      logic [4:0]  rx_ack;
      logic [4:0]  timeout_seq;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [4:0]  frame_seq;
      logic [4:0]  ack_num;
      logic [63:0] pkt_word;
      logic [4:0]  timer_seq;
      logic        network_enable;
      logic        last;
   } rsp_item_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SEND_RD,
      S_SEND_OUT,
      S_NAK,
      S_ACK,
      S_RX_CHK,
      S_DLV_CHK,
      S_DLV_OUT,
      S_NAK_RESEND,
      S_WALK,
      S_STATUS
   } state_type;

endpackage

/* rtl/selective_repeat_arq_link.sv */
// Selective-repeat ARQ link engine: windows, packet buffers and event sequencer.
// One event request is taken at a time and yields one or more result items, the
// last being the status item. Each event is accepted and dispatched; a data send
// first reads the transmit buffer; a good received frame passes through the
// retransmit decision and the acknowledge walk, a data frame also through the
// window check and, when it is stored, the delivery scan, and each delivery reads
// the receive buffer before it is output. A result that is not taken holds the
// sequencer until it is. A new request is taken while the previous status item
// still waits in the output register.
module selective_repeat_arq_link import srarq_pkg::*; #(
   parameter int SEQ_MAX     = 31,
   parameter int PACKET_BITS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data
);

   localparam int SEQ_SPACE = SEQ_MAX + 1;
   localparam int NR_BUFS   = SEQ_SPACE / 2;
   localparam int SEQ_W     = $clog2(SEQ_SPACE);
   localparam int CW        = (SEQ_W > 5) ? SEQ_W : 5;
   localparam int SLOT_W    = $clog2(NR_BUFS);
   localparam int OUT_W     = $clog2(NR_BUFS + 1);
   localparam int GRD_W     = $clog2(SEQ_SPACE + 1);
   localparam logic [63:0] PKT_MASK = {64{1'b1}} >> (64 - PACKET_BITS);

   function automatic logic [SLOT_W-1:0] slot_of(input logic [CW-1:0] x);
      logic [SLOT_W-1:0] r;
      r = '0;
      for (int i = 0; i < 2**CW; i++) begin
         if (x == CW'(i)) r = SLOT_W'(i % NR_BUFS);
      end
      return r;
   endfunction

   function automatic logic [SEQ_W-1:0] want_of(input logic [4:0] a);
      logic [SEQ_W-1:0] r;
      r = '0;
      for (int i = 0; i < 32; i++) begin
         if (a == 5'(i)) r = SEQ_W'((i + 1) % SEQ_SPACE);
      end
      return r;
   endfunction

   function automatic logic in_win(input logic [CW-1:0] lo, input logic [CW-1:0] x,
                                   input logic [CW-1:0] hi);
      return (lo <= x && x < hi) || (hi < lo && x < hi) || (hi < lo && lo <= x);
   endfunction

   function automatic logic [SEQ_W-1:0] seq_next(input logic [SEQ_W-1:0] k);
      return (k == SEQ_W'(SEQ_MAX)) ? '0 : k + 1'b1;
   endfunction

   function automatic logic [4:0] to5(input logic [CW-1:0] x);
      return x[4:0];
   endfunction

   state_type         state_ff, state_in;
   req_item_type      req_ff, req_in;
   logic [SEQ_W-1:0]  nts_ff, nts_in, old_ff, old_in, exp_ff, exp_in, rwe_ff, rwe_in;
   logic [OUT_W-1:0]  out_ff, out_in;
   logic              phys_ff, phys_in, nak_ff, nak_in;
   logic [NR_BUFS-1:0] arr_ff, arr_in;
   logic [CW-1:0]     sseq_ff, sseq_in;
   logic [GRD_W-1:0]  grd_ff, grd_in;
   rsp_item_type      rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [PACKET_BITS-1:0] tx_mem [NR_BUFS];
   logic [PACKET_BITS-1:0] rx_mem [NR_BUFS];
   logic [PACKET_BITS-1:0] rd_ff;

   logic              tx_we, rx_we, rd_en, rd_rx;
   logic [SLOT_W-1:0] wr_addr, rd_addr;
   logic [PACKET_BITS-1:0] wr_data;
   logic              emit, can_emit;
   rsp_item_type      item;

   logic [CW-1:0]     cur_ack, exp_c, rwe_c, old_c, nts_c, seq_c, ack_c, want_c;
   logic              rx_in_win, nak_in_win, walk_go, pkt_room;

   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign exp_c   = CW'(exp_ff);
   assign rwe_c   = CW'(rwe_ff);
   assign old_c   = CW'(old_ff);
   assign nts_c   = CW'(nts_ff);
   assign seq_c   = CW'(req_ff.rx_seq);
   assign ack_c   = CW'(req_ff.rx_ack);
   assign want_c  = CW'(want_of(req_ff.rx_ack));
   assign cur_ack = (exp_ff == '0) ? CW'(SEQ_MAX) : CW'(exp_ff - 1'b1);
   assign rx_in_win  = in_win(exp_c, seq_c, rwe_c);
   assign nak_in_win = in_win(old_c, want_c, nts_c);
   assign walk_go    = (grd_ff < GRD_W'(SEQ_SPACE)) && in_win(old_c, ack_c, nts_c);
   assign pkt_room   = (out_ff < OUT_W'(NR_BUFS));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            unique case (req_ff.req_type)
               EV_PACKET:  state_in = pkt_room ? S_SEND_RD : S_STATUS;
               EV_DATA_TO: state_in = S_SEND_RD;
               EV_ACK_TO:  state_in = S_ACK;
               EV_FRAME: begin
                  priority if (!req_ff.rx_good) state_in = nak_ff ? S_NAK : S_STATUS;
                  else if (req_ff.rx_kind == KIND_DATA)
                     state_in = (seq_c != exp_c && nak_ff) ? S_NAK : S_RX_CHK;
                  else state_in = S_NAK_RESEND;
               end
               default: state_in = S_STATUS;
            endcase
         end
         S_SEND_RD:  state_in = S_SEND_OUT;
         S_SEND_OUT: if (can_emit)
            state_in = (req_ff.req_type == EV_FRAME) ? S_WALK : S_STATUS;
         S_NAK:      if (can_emit) state_in = req_ff.rx_good ? S_RX_CHK : S_STATUS;
         S_ACK:      if (can_emit) state_in = S_STATUS;
         S_RX_CHK:
            state_in = (rx_in_win && !arr_ff[slot_of(seq_c)]) ? S_DLV_CHK : S_NAK_RESEND;
         S_DLV_CHK:
            state_in = (grd_ff < GRD_W'(NR_BUFS) && arr_ff[slot_of(exp_c)]) ?
                       S_DLV_OUT : S_NAK_RESEND;
         S_DLV_OUT:  if (can_emit) state_in = S_DLV_CHK;
         S_NAK_RESEND:
            state_in = (req_ff.rx_kind == KIND_NAK && nak_in_win) ? S_SEND_RD : S_WALK;
         S_WALK:     if (!walk_go) state_in = S_STATUS;
         S_STATUS:   if (can_emit) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and result items
   always_comb begin
      req_in  = req_ff;
      nts_in  = nts_ff;
      old_in  = old_ff;
      exp_in  = exp_ff;
      rwe_in  = rwe_ff;
      out_in  = out_ff;
      phys_in = phys_ff;
      nak_in  = nak_ff;
      arr_in  = arr_ff;
      sseq_in = sseq_ff;
      grd_in  = grd_ff;
      tx_we   = 1'b0;
      rx_we   = 1'b0;
      wr_addr = '0;
      wr_data = req_ff.payload[PACKET_BITS-1:0];
      rd_en   = 1'b0;
      rd_rx   = 1'b0;
      rd_addr = '0;
      emit    = 1'b0;
      item    = '0;
      unique case (state_ff)
         S_IDLE: if (req_valid) req_in = req_data;
         S_DISPATCH: begin
            grd_in = '0;
            if (req_ff.req_type == EV_PACKET && pkt_room) begin
               out_in  = out_ff + 1'b1;
               tx_we   = 1'b1;
               wr_addr = slot_of(nts_c);
               sseq_in = nts_c;
               nts_in  = seq_next(nts_ff);
            end
            if (req_ff.req_type == EV_PHYS_RDY) phys_in = 1'b1;
            if (req_ff.req_type == EV_DATA_TO) sseq_in = CW'(req_ff.timeout_seq);
         end
         S_SEND_RD: begin
            rd_en   = 1'b1;
            rd_addr = slot_of(sseq_ff);
         end
         S_SEND_OUT: if (can_emit) begin
            emit = 1'b1;
            item.action     = ACT_SEND_DATA;
            item.frame_seq  = to5(sseq_ff);
            item.ack_num    = to5(cur_ack);
            item.pkt_word   = 64'(rd_ff) & PKT_MASK;
            item.timer_seq  = to5(sseq_ff);
            phys_in = 1'b0;
         end
         S_NAK: if (can_emit) begin
            emit = 1'b1;
            item.action  = ACT_SEND_NAK;
            item.ack_num = to5(cur_ack);
            nak_in  = 1'b0;
            phys_in = 1'b0;
         end
         S_ACK: if (can_emit) begin
            emit = 1'b1;
            item.action  = ACT_SEND_ACK;
            item.ack_num = to5(cur_ack);
            phys_in = 1'b0;
         end
         S_RX_CHK: begin
            grd_in = '0;
            if (rx_in_win && !arr_ff[slot_of(seq_c)]) begin
               arr_in[slot_of(seq_c)] = 1'b1;
               rx_we   = 1'b1;
               wr_addr = slot_of(seq_c);
            end
         end
         S_DLV_CHK: begin
            rd_en   = 1'b1;
            rd_rx   = 1'b1;
            rd_addr = slot_of(exp_c);
         end
         S_DLV_OUT: if (can_emit) begin
            emit = 1'b1;
            item.action     = ACT_DELIVER;
            item.frame_seq  = to5(exp_c);
            item.pkt_word   = 64'(rd_ff) & PKT_MASK;
            arr_in[slot_of(exp_c)] = 1'b0;
            nak_in = 1'b1;
            exp_in = seq_next(exp_ff);
            rwe_in = seq_next(rwe_ff);
            grd_in = grd_ff + 1'b1;
         end
         S_NAK_RESEND: begin
            grd_in  = '0;
            sseq_in = want_c;
         end
         S_WALK: if (walk_go && can_emit) begin
            emit = 1'b1;
            item.action    = ACT_STOP_TMR;
            item.timer_seq = to5(old_c);
            if (out_ff != '0) out_in = out_ff - 1'b1;
            old_in = seq_next(old_ff);
            grd_in = grd_ff + 1'b1;
         end
         S_STATUS: if (can_emit) begin
            emit = 1'b1;
            item.action         = ACT_STATUS;
            item.network_enable = pkt_room && phys_ff;
            item.last           = 1'b1;
         end
         default: ;
      endcase
      rsp_in       = emit ? item : rsp_ff;
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (tx_we) tx_mem[wr_addr] <= wr_data;
      if (rx_we) rx_mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= rd_rx ? rx_mem[rd_addr] : tx_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      sseq_ff <= sseq_in;
      grd_ff  <= grd_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         nts_ff       <= '0;
         old_ff       <= '0;
         exp_ff       <= '0;
         rwe_ff       <= SEQ_W'(NR_BUFS);
         out_ff       <= '0;
         phys_ff      <= 1'b0;
         nak_ff       <= 1'b1;
         arr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nts_ff       <= nts_in;
         old_ff       <= old_in;
         exp_ff       <= exp_in;
         rwe_ff       <= rwe_in;
         out_ff       <= out_in;
         phys_ff      <= phys_in;
         nak_ff       <= nak_in;
         arr_ff       <= arr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      out_ff <= OUT_W'(NR_BUFS))
      else $error("outstanding count above window size");

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_DISPATCH)
      else $error("accepted request not dispatched");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_STATUS && can_emit |=> rsp_valid && rsp_data.last && req_ready)
      else $error("status item missing at end of request");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the selective-repeat ARQ link engine.
`timescale 1ns / 1ps

import srarq_pkg::*;

class arq_scoreboard;
   localparam int WIN = 16;

   bit [4:0]  next_tx, oldest_tx, expected_rx, rx_end, in_flight;
   bit        phys_rdy, nak_ok;
   bit        arrived[WIN];
   bit        tx_written[WIN];
   bit [63:0] rx_buf[WIN];
   bit [63:0] tx_buf[WIN];
   rsp_item_type expected_rsp[$];
   int        errors;

   function new();
      next_tx = 0; oldest_tx = 0; expected_rx = 0; rx_end = WIN; in_flight = 0;
      phys_rdy = 0; nak_ok = 1; errors = 0;
      foreach (arrived[i]) begin
         arrived[i] = 0;
         tx_written[i] = 0;
      end
   endfunction

   function bit in_win(bit [4:0] lo, bit [4:0] x, bit [4:0] hi);
      return (lo <= x && x < hi) || (hi < lo && x < hi) || (hi < lo && lo <= x);
   endfunction

   function void push(bit [2:0] act, bit [4:0] seq, bit [4:0] ack, bit [63:0] data,
                      bit [4:0] tseq, bit en, bit last);
      rsp_item_type r;
      r.action = act; r.frame_seq = seq; r.ack_num = ack; r.pkt_word = data;
      r.timer_seq = tseq; r.network_enable = en; r.last = last;
      expected_rsp.push_back(r);
   endfunction

   function void predict_data_send(bit [4:0] seq);
      push(ACT_SEND_DATA, seq, expected_rx - 5'd1, tx_buf[seq % WIN], seq, 0, 0);
      phys_rdy = 0;
   endfunction

   function void send_nak();
      push(ACT_SEND_NAK, 0, expected_rx - 5'd1, 0, 0, 0, 0);
      nak_ok = 0;
      phys_rdy = 0;
   endfunction

   function void ack_walk(bit [4:0] ack);
      int guard;
      guard = 0;
      while (guard < 32 && in_win(oldest_tx, ack, next_tx)) begin
         if (in_flight > 0) in_flight--;
         push(ACT_STOP_TMR, 0, 0, 0, oldest_tx, 0, 0);
         oldest_tx++;
         guard++;
      end
   endfunction

   function void note_request(req_item_type q);
      int guard;
      bit [4:0] want;
      case (q.req_type)
         EV_PACKET: begin
            if (in_flight < WIN) begin
               in_flight++;
               tx_buf[next_tx % WIN] = q.payload;
               tx_written[next_tx % WIN] = 1;
               predict_data_send(next_tx);
               next_tx++;
            end
         end
         EV_PHYS_RDY: phys_rdy = 1;
         EV_FRAME: begin
            if (!q.rx_good) begin
               if (nak_ok) send_nak();
            end else begin
               if (q.rx_kind == KIND_DATA) begin
                  if (q.rx_seq != expected_rx && nak_ok) send_nak();
                  if (in_win(expected_rx, q.rx_seq, rx_end) && !arrived[q.rx_seq % WIN]) begin
                     arrived[q.rx_seq % WIN] = 1;
                     rx_buf[q.rx_seq % WIN] = q.payload;
                     guard = 0;
                     while (guard < WIN && arrived[expected_rx % WIN]) begin
                        push(ACT_DELIVER, expected_rx, 0, rx_buf[expected_rx % WIN], 0, 0, 0);
                        arrived[expected_rx % WIN] = 0;
                        nak_ok = 1;
                        expected_rx++;
                        rx_end++;
                        guard++;
                     end
                  end
               end
               if (q.rx_kind == KIND_NAK) begin
                  want = q.rx_ack + 5'd1;
                  if (in_win(oldest_tx, want, next_tx)) predict_data_send(want);
               end
               ack_walk(q.rx_ack);
            end
         end
         EV_DATA_TO: predict_data_send(q.timeout_seq);
         EV_ACK_TO: begin
            push(ACT_SEND_ACK, 0, expected_rx - 5'd1, 0, 0, 0, 0);
            phys_rdy = 0;
         end
         default: ;
      endcase
      push(ACT_STATUS, 0, 0, 0, 0, (in_flight < WIN) && phys_rdy, 1);
   endfunction

   task report(string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      errors++;
   endtask

   task check_response(rsp_item_type got);
      rsp_item_type e;
      if (expected_rsp.size() == 0) begin
         report($sformatf("unexpected response %p", got));
         return;
      end
      e = expected_rsp.pop_front();
      if (got.action !== e.action)
         report($sformatf("action %0d, want %0d", got.action, e.action));
      if (got.frame_seq !== e.frame_seq)
         report($sformatf("frame_seq %0d, want %0d", got.frame_seq, e.frame_seq));
      if (got.ack_num !== e.ack_num)
         report($sformatf("ack_num %0d, want %0d", got.ack_num, e.ack_num));
      if (got.pkt_word !== e.pkt_word)
         report($sformatf("pkt_word %h, want %h", got.pkt_word, e.pkt_word));
      if (got.timer_seq !== e.timer_seq)
         report($sformatf("timer_seq %0d, want %0d", got.timer_seq, e.timer_seq));
      if (got.network_enable !== e.network_enable)
         report($sformatf("network_enable %b, want %b", got.network_enable,
                          e.network_enable));
      if (got.last !== e.last)
         report($sformatf("last %b, want %b", got.last, e.last));
   endtask
endclass

module tb;
   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 99;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_ready;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 0;
   rsp_item_type rsp_data;

   arq_scoreboard sb = new();
   int send_idle_pct = 6;
   int recv_idle_pct = 72;
   int quiet_cycles = 0;

   always #2 clock = ~clock;

   selective_repeat_arq_link DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) quiet_cycles <= 0;
      else if (!reset) quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Call at a falling edge; returns at the falling edge after acceptance.
   task send_request(req_item_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data  <= q;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note_request(q);
      @(negedge clock);
   endtask

   function req_item_type make_event(bit [2:0] ev);
      req_item_type q;
      q = '0;
      q.req_type = ev;
      q.payload = {$urandom, $urandom};
      return q;
   endfunction

   function req_item_type make_frame(bit good, bit [1:0] kind, bit [4:0] seq,
                                     bit [4:0] ack);
      req_item_type q;
      q = make_event(EV_FRAME);
      q.rx_good = good; q.rx_kind = kind; q.rx_seq = seq; q.rx_ack = ack;
      q.timeout_seq = 5'($urandom);
      return q;
   endfunction

   // Mostly well-formed traffic driven off the predicted link state.
   function req_item_type make_random_request();
      req_item_type q;
      int pick;
      bit [4:0] ack;
      int slots[$];
      pick = $urandom_range(99);
      ack = sb.oldest_tx - 5'd1 + 5'($urandom_range(sb.in_flight));
      if (pick < 25) q = make_event(EV_PACKET);
      else if (pick < 35) q = make_event(EV_PHYS_RDY);
      else if (pick < 55)
         q = make_frame(1, KIND_DATA, sb.expected_rx + 5'($urandom_range(3)), ack);
      else if (pick < 63) q = make_frame(1, KIND_ACK, 0, ack);
      else if (pick < 68) q = make_frame(1, KIND_NAK, 0, ack);
      else if (pick < 78) begin
         q = make_frame(1'($urandom_range(1)), 2'($urandom_range(3)), 5'($urandom),
                        5'($urandom));
      end else if (pick < 87) begin
         foreach (sb.tx_written[i]) if (sb.tx_written[i]) slots.push_back(i);
         if (slots.size() == 0) q = make_event(EV_ACK_TO);
         else begin
            q = make_event(EV_DATA_TO);
            q.timeout_seq = 5'(slots[$urandom_range(slots.size() - 1)]
                               + 16 * $urandom_range(1));
         end
      end else if (pick < 95) q = make_event(EV_ACK_TO);
      else q = make_event(3'($urandom_range(5, 7)));
      // noise fields on unused inputs
      if (q.req_type != EV_FRAME) begin
         q.rx_good = 1'($urandom); q.rx_kind = 2'($urandom); q.rx_seq = 5'($urandom);
         q.rx_ack = 5'($urandom);
         if (q.req_type != EV_DATA_TO) q.timeout_seq = 5'($urandom);
      end
      return q;
   endfunction

   task wait_drained();
      while (sb.expected_rsp.size() != 0) @(negedge clock);
   endtask

   initial begin
      req_item_type q;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: bad frame, window walks, reorder, extremes, unknown codes
      send_request(make_frame(0, KIND_DATA, 0, 0));
      send_request(make_event(EV_PHYS_RDY));
      q = make_event(EV_PACKET); q.payload = '1; send_request(q);
      q = make_event(EV_PACKET); q.payload = '0; send_request(q);
      send_request(make_event(EV_PACKET));
      q = make_event(EV_DATA_TO); q.timeout_seq = 1; send_request(q);
      send_request(make_event(EV_ACK_TO));
      send_request(make_frame(1, KIND_NAK, 5'd0, 5'd31));
      send_request(make_frame(1, KIND_DATA, 5'd0, 5'd31));
      send_request(make_frame(1, KIND_DATA, 5'd2, 5'd0));
      send_request(make_frame(1, KIND_DATA, 5'd2, 5'd0));
      send_request(make_frame(1, KIND_DATA, 5'd1, 5'd2));
      send_request(make_frame(1, 2'd3, 5'd31, 5'd31));
      send_request(make_frame(1, KIND_ACK, 5'd31, 5'd31));
      send_request(make_event(3'd7));
      send_request(make_event(EV_PHYS_RDY));
      repeat (17) begin
         q = make_event(EV_PACKET);
         send_request(q);
      end
      send_request(make_frame(1, KIND_ACK, 5'd0, 5'd18));

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 72 : 0;
         recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 6 : 0;
         for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase == 1 && n == RANDOM_ITEMS / 2) begin
               req_valid <= 0;
               @(negedge clock);
               wait_drained();
            end
            send_request(make_random_request());
         end
      end
      req_valid <= 0;
      wait_drained();
      repeat (50) @(negedge clock);
      if (sb.errors == 0 && sb.expected_rsp.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
